// File: rtl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// Used by wgm_csr, wgm_cell and wildcard_glob_matcher; no dependencies.
package wgm_pkg;

   localparam int MAX_PATTERN_BYTES_DEF = 16;

   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_ANY  = 8'h3F;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_REG_W  = 5;

   localparam logic [CSR_ADDR_W-1:0] ADDR_CHARS_LOW  = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CHARS_HIGH = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LENGTH     = 5'd16;

   // Chain signals handed from one position cell to the next.
   typedef struct packed {
      logic carry_cur;
      logic advance;
      logic carry_next;
   } link_type;

   // Per-transaction control broadcast to every cell.
   typedef struct packed {
      logic       accept;
      logic       finish;
      logic       no_char;
      logic [7:0] text_char;
   } cell_ctrl_type;

endpackage

// File: rtl/wildcard_glob_matcher.sv
// Top level of the wildcard glob matcher: a row of position cells, the
// configuration registers and the result register. Depends on wgm_pkg,
// wgm_csr and wgm_cell.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | text_char, end_of_text, no_char
//   rsp     | out       | rsp_valid / rsp_stall  | matched
//   csr     | in        | APB psel/penable/pready| 64-bit pattern registers, 5-bit length register
//
// One transaction is taken per clock while req_stall is low; the whole live-set
// update runs through a ripple chain of MAX_PATTERN_BYTES+1 cells within that cycle.
// A transaction that ends the text gives its flag on rsp in the cycle after it is taken.
// reset is synchronous: only position zero is live, the registers read zero.
// req_stall is high only while a result is held and rsp_stall is high.
module wildcard_glob_matcher import wgm_pkg::*; #(
   parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_text_char,
   input  logic                  req_end_of_text,
   input  logic                  req_no_char,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_matched,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int NPOS  = MAX_PATTERN_BYTES + 1;
   localparam int LEN_W = $clog2(NPOS);

   logic [63:0]          chars_low;
   logic [63:0]          chars_high;
   logic [LEN_REG_W-1:0] pattern_length;
   logic [127:0]         pattern;
   logic [LEN_W-1:0]     len_eff;
   cell_ctrl_type        ctrl;
   link_type             links [NPOS+1];
   logic [NPOS-1:0]      result_bits;
   logic                 accept;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 rsp_matched_ff;
   logic                 rsp_matched_in;

   wgm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .chars_low      (chars_low),
      .chars_high     (chars_high),
      .pattern_length (pattern_length)
   );

   assign pattern = {chars_high, chars_low};
   assign len_eff = (pattern_length > LEN_REG_W'(MAX_PATTERN_BYTES)) ?
                    LEN_W'(MAX_PATTERN_BYTES) : LEN_W'(pattern_length);

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctrl.accept    = accept;
   assign ctrl.finish    = req_end_of_text;
   assign ctrl.no_char   = req_no_char;
   assign ctrl.text_char = req_text_char;

   assign links[0] = '0;

   for (genvar i = 0; i < NPOS; i++) begin : g_cell
      logic [7:0] pat_byte;
      if (i < MAX_PATTERN_BYTES) begin : g_byte
         assign pat_byte = pattern[8*i +: 8];
      end else begin : g_tail
         assign pat_byte = '0;
      end

      wgm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .pat_byte   (pat_byte),
         .in_use     (len_eff > LEN_W'(i)),
         .in_keep    (len_eff >= LEN_W'(i)),
         .init_bit   (1'(i == 0)),
         .link_in    (links[i]),
         .link_out   (links[i+1]),
         .result_bit (result_bits[i])
      );
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      if (accept && req_end_of_text) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = result_bits[len_eff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_matched = rsp_matched_ff;

endmodule

// File: rtl/wgm_csr.sv
// Configuration registers of the wildcard glob matcher (APB-style port).
// Depends on wgm_pkg for the address map and widths.
module wgm_csr import wgm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [63:0]           chars_low,
   output logic [63:0]           chars_high,
   output logic [LEN_REG_W-1:0]  pattern_length
);

   logic [63:0]          chars_low_ff;
   logic [63:0]          chars_high_ff;
   logic [LEN_REG_W-1:0] length_ff;
   logic                 write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
         length_ff     <= '0;
      end else if (write_en) begin
         case (csr_paddr)
            ADDR_CHARS_LOW:  chars_low_ff  <= csr_pwdata;
            ADDR_CHARS_HIGH: chars_high_ff <= csr_pwdata;
            ADDR_LENGTH:     length_ff     <= csr_pwdata[LEN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         ADDR_CHARS_LOW:  csr_prdata = chars_low_ff;
         ADDR_CHARS_HIGH: csr_prdata = chars_high_ff;
         ADDR_LENGTH:     csr_prdata = {{(CSR_DATA_W-LEN_REG_W){1'b0}}, length_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign chars_low      = chars_low_ff;
   assign chars_high     = chars_high_ff;
   assign pattern_length = length_ff;

endmodule

// File: rtl/wgm_cell.sv
// One pattern-position cell: holds the live bit of its position and
// passes star closure and advance bits to the next cell. Depends on wgm_pkg.
module wgm_cell import wgm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [7:0]    pat_byte,
   input  logic          in_use,
   input  logic          in_keep,
   input  logic          init_bit,
   input  link_type      link_in,
   output link_type      link_out,
   output logic          result_bit
);

   logic live_ff;
   logic live_in;
   logic is_star;
   logic hits;
   logic cur_bit;
   logic next_bit;
   logic final_bit;

   assign is_star = (pat_byte == CH_STAR);
   assign hits    = (pat_byte == CH_ANY) || (pat_byte == ctrl.text_char);

   // Closure of the stored set: a live star position also makes the next one live.
   assign cur_bit            = (live_ff && in_keep) || link_in.carry_cur;
   assign link_out.carry_cur = cur_bit && is_star && in_use;

   // A star stays on its own position; any other match moves one position on.
   assign link_out.advance = cur_bit && in_use && !is_star && hits;
   assign next_bit         = (cur_bit && in_use && is_star) || link_in.advance;

   assign final_bit           = next_bit || link_in.carry_next;
   assign link_out.carry_next = final_bit && is_star && in_use;

   assign result_bit = ctrl.no_char ? cur_bit : final_bit;

   always_comb begin
      live_in = live_ff;
      if (ctrl.accept) begin
         live_in = ctrl.finish ? init_bit : result_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= init_bit;
      end else begin
         live_ff <= live_in;
      end
   end

endmodule

// File: dv/wildcard_glob_matcher_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for wildcard_glob_matcher: streams texts against patterns
// loaded over the APB port and predicts each match flag from a live-position set.
// Depends on wgm_pkg and the wildcard_glob_matcher RTL.
module wildcard_glob_matcher_tb;
   import wgm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int ITEM_TARGET  = 1150;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 4;
   localparam int NPOS         = MAX_PATTERN_BYTES_DEF;

   localparam logic [NPOS:0] LIVE_START = {{NPOS{1'b0}}, 1'b1};

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_text_char   = '0;
   logic                  req_end_of_text = 1'b0;
   logic                  req_no_char     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic                  rsp_matched;
   logic                  csr_psel        = 1'b0;
   logic                  csr_penable     = 1'b0;
   logic                  csr_pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr       = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata      = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Shadow of the pattern registers and of the block's live-position set.
   logic [63:0]          pattern_low  = '0;
   logic [63:0]          pattern_high = '0;
   logic [LEN_REG_W-1:0] pattern_len  = '0;
   logic [NPOS:0]        live_set     = LIVE_START;

   logic       expected_matches[$];
   logic [7:0] text_buf[$];
   int         text_items_sent = 0;
   int         mismatch_count  = 0;
   int         cycle_count     = 0;
   bit         send_gaps_on    = 1'b0;
   bit         stall_on        = 1'b0;
   bit         hold_req        = 1'b0;

   wildcard_glob_matcher DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_char(req_text_char),
      .req_end_of_text(req_end_of_text),
      .req_no_char(req_no_char),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_matched(rsp_matched),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function automatic logic [7:0] pattern_byte(input int i);
      if (i < 8) return pattern_low[8*i +: 8];
      return pattern_high[8*(i-8) +: 8];
   endfunction

   function automatic int active_length();
      if (pattern_len > NPOS) return NPOS;
      return int'(pattern_len);
   endfunction

   function automatic void add_text_char(input logic [7:0] ch);
      text_buf.insert(text_buf.size(), ch);
   endfunction

   // Positions past the pattern end are dropped, then every live star also
   // makes the position after it live, since a star may match nothing.
   function automatic logic [NPOS:0] close_stars(input logic [NPOS:0] s, input int n);
      logic [NPOS:0] r;
      int i;
      r = s;
      for (i = n + 1; i <= NPOS; i++) r[i] = 1'b0;
      for (i = 0; i < n; i++) begin
         if (r[i] && pattern_byte(i) == CH_STAR) r[i+1] = 1'b1;
      end
      return r;
   endfunction

   function automatic void consume_item(input logic [7:0] ch, input logic last,
                                        input logic empty);
      logic [NPOS:0] cur;
      logic [NPOS:0] nxt;
      int n;
      int i;
      n = active_length();
      cur = close_stars(live_set, n);
      if (!empty) begin
         nxt = '0;
         for (i = 0; i < n; i++) begin
            if (cur[i]) begin
               if (pattern_byte(i) == CH_STAR) nxt[i] = 1'b1;
               else if (pattern_byte(i) == CH_ANY || pattern_byte(i) == ch) nxt[i+1] = 1'b1;
            end
         end
         cur = close_stars(nxt, n);
      end
      if (last) begin
         expected_matches.insert(expected_matches.size(), cur[n]);
         live_set = LIVE_START;
      end else begin
         live_set = cur;
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 30) $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : result_check
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected result transaction, matched=%0b",
                                      rsp_matched));
         end else begin
            want = expected_matches.pop_front();
            if (rsp_matched !== want)
               report_mismatch($sformatf("matched=%0b, predicted %0b", rsp_matched, want));
         end
      end
   end

   // ---------------------------------------------------------------- idling

   function automatic int idle_length();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   // The receiver stalls at random, or for one long stretch when asked.
   initial begin : rsp_backpressure
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && stall_on && $urandom_range(0, 99) < 25) begin
            stall_left = idle_length();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic [7:0] ch, input logic last, input logic empty);
      int gap;
      gap = (send_gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_char   <= ch;
      req_end_of_text <= last;
      req_no_char     <= empty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      consume_item(ch, last, empty);
      if (last || !empty) text_items_sent++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (addr)
         ADDR_CHARS_LOW:  pattern_low  = data;
         ADDR_CHARS_HIGH: pattern_high = data;
         ADDR_LENGTH:     pattern_len  = data[LEN_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [63:0] len_word);
      wait_results_drained();
      write_csr(ADDR_CHARS_LOW, lo);
      write_csr(ADDR_CHARS_HIGH, hi);
      write_csr(ADDR_LENGTH, len_word);
   endtask

   task automatic load_pattern_string(input string p, input logic [63:0] len_word);
      logic [127:0] packed_chars;
      int i;
      packed_chars = '0;
      for (i = 0; i < p.len() && i < 16; i++) packed_chars[8*i +: 8] = p[i];
      load_pattern(packed_chars[63:0], packed_chars[127:64], len_word);
   endtask

   task automatic send_string(input string s);
      int i;
      if (s.len() == 0) send_item(8'($urandom), 1'b1, 1'b1);
      for (i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1, 1'b0);
   endtask

   function automatic logic [7:0] pick_text_char();
      case ($urandom_range(0, 9))
         0, 1:    return "a";
         2, 3:    return "b";
         4:       return "c";
         5:       return CH_STAR;
         6:       return CH_ANY;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_pattern_char();
      case ($urandom_range(0, 19))
         0, 1, 2, 3:     return "a";
         4, 5, 6:        return "b";
         7:              return "c";
         8, 9, 10, 11:   return CH_STAR;
         12, 13, 14:     return CH_ANY;
         default:        return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic load_random_pattern();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] len_word;
      int i;
      int r;
      for (i = 0; i < 8; i++) begin
         lo[8*i +: 8] = pick_pattern_char();
         hi[8*i +: 8] = pick_pattern_char();
      end
      r = $urandom_range(0, 99);
      len_word = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 0) len_word = '0;
      if (r < 5)       len_word[4:0] = 5'd0;
      else if (r < 70) len_word[4:0] = 5'($urandom_range(1, 8));
      else if (r < 88) len_word[4:0] = 5'($urandom_range(9, 16));
      else             len_word[4:0] = 5'($urandom_range(17, 31));
      load_pattern(lo, hi, len_word);
   endtask

   // Expands the current pattern into a text that matches it, then spoils
   // it now and then so that misses come up as well.
   function automatic void build_matching_text();
      int i;
      int k;
      int r;
      logic [7:0] p;
      text_buf.delete();
      for (i = 0; i < active_length(); i++) begin
         p = pattern_byte(i);
         if (p == CH_STAR) begin
            for (k = $urandom_range(0, 3); k > 0; k--) add_text_char(pick_text_char());
         end else if (p == CH_ANY) begin
            add_text_char(8'($urandom_range(0, 255)));
         end else begin
            add_text_char(p);
         end
      end
      r = $urandom_range(0, 99);
      k = (text_buf.size() > 0) ? $urandom_range(0, text_buf.size() - 1) : 0;
      if (r < 15 && text_buf.size() > 0) text_buf[k] = pick_text_char();
      else if (r < 25 && text_buf.size() > 0) text_buf.delete(k);
      else if (r < 35) add_text_char(pick_text_char());
   endfunction

   function automatic void build_noise_text();
      int k;
      text_buf.delete();
      for (k = $urandom_range(0, 6); k > 0; k--) add_text_char(pick_text_char());
   endfunction

   // Sends text_buf[first..stop-1], with stray empty transactions mixed in.
   task automatic send_span(input int first, input int stop, input bit ends);
      int i;
      bit tail_empty;
      tail_empty = ends && (stop == first || $urandom_range(0, 11) == 0);
      for (i = first; i < stop; i++) begin
         if ($urandom_range(0, 12) == 0) send_item(pick_text_char(), 1'b0, 1'b1);
         send_item(text_buf[i], ends && !tail_empty && i == stop - 1, 1'b0);
      end
      if (tail_empty) send_item(pick_text_char(), 1'b1, 1'b1);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_gaps_on = 1'b0;
      stall_on     = 1'b1;
      load_pattern('0, '0, 64'd0);
      send_string("");
      send_string("q");
      load_pattern('1, '1, 64'd2);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      load_pattern('0, '0, 64'd1);
      send_item(8'h00, 1'b1, 1'b0);
      load_pattern_string("a?c", 64'd3);
      send_string("abc");
      send_string("a*c");
      send_string("ac");
      // A star in the text is an ordinary byte; only pattern stars are wildcards.
      load_pattern_string("*b", 64'd2);
      send_string("*");
      send_string("*b");
      load_pattern_string("ab", 64'd2);
      send_item("a", 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item("b", 1'b1, 1'b0);
      send_item("a", 1'b0, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      load_pattern_string("***************?", 64'd16);
      send_string("x");
      load_pattern_string("***************?", 64'd31);
      send_string("");
      send_string("y");
   endtask

   task automatic test_midtext_rewrite();
      int k;
      int cut;
      send_gaps_on = 1'b1;
      stall_on     = 1'b1;
      for (k = 0; k < 10; k++) begin
         load_random_pattern();
         build_matching_text();
         while (text_buf.size() < 2) add_text_char(pick_text_char());
         cut = $urandom_range(1, text_buf.size() - 1);
         send_span(0, cut, 1'b0);
         load_random_pattern();
         send_span(cut, text_buf.size(), 1'b1);
      end
   endtask

   task automatic test_result_backpressure();
      int k;
      load_pattern_string("a*", 64'd2);
      send_gaps_on = 1'b0;
      stall_on     = 1'b0;
      hold_req     = 1'b1;
      @(posedge clock);
      for (k = 0; k < 12; k++) send_string((k % 2 == 0) ? "ab" : "ba");
      wait_results_drained();
   endtask

   task automatic test_random_texts();
      int n_texts;
      int k;
      while (text_items_sent < ITEM_TARGET) begin
         send_gaps_on = ($urandom_range(0, 3) != 0);
         stall_on     = ($urandom_range(0, 3) != 0);
         load_random_pattern();
         n_texts = $urandom_range(8, 30);
         for (k = 0; k < n_texts; k++) begin
            if ($urandom_range(0, 9) == 0) build_noise_text();
            else build_matching_text();
            send_span(0, text_buf.size(), 1'b1);
         end
      end
   endtask

   initial begin : main_sequence
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_midtext_rewrite();
      test_result_backpressure();
      test_random_texts();
      wait_results_drained();
      if (expected_matches.size() != 0) report_mismatch("match flags still outstanding");
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: wildcard_glob_matcher.f
rtl/wgm_pkg.sv
rtl/wgm_csr.sv
rtl/wgm_cell.sv
rtl/wildcard_glob_matcher.sv
dv/wildcard_glob_matcher_tb.sv
